// ----- rtl/nnt_pkg.sv -----
// ----------------------------------------------------------------------------
// nnt_pkg
// Shared types for the nearest-neighbour tour block: item structs, datapath
// commands and the status group returned to the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package nnt_pkg;

  localparam int unsigned COST_W   = 22;
  localparam int unsigned COST_SAT = 4194303;

  typedef enum logic [0:0] {
    OP_WRITE_DIST = 1'b0,
    OP_START      = 1'b1
  } item_op_e;

  typedef struct packed {
    logic [0:0]  op;
    logic [5:0]  row_city;
    logic [5:0]  col_city;
    logic [15:0] distance;
    logic [5:0]  start_city;
  } in_item_t;

  typedef struct packed {
    logic [5:0]        position;
    logic [5:0]        city;
    logic [COST_W-1:0] tour_cost;
    logic              last;
  } out_item_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_START,
    DP_G_SCAN,
    DP_G_COMMIT,
    DP_C_INIT,
    DP_C_FIRST,
    DP_C_STEP,
    DP_C_ACC,
    DP_C_END,
    DP_S_INIT,
    DP_S_IA,
    DP_S_IB,
    DP_S_IC,
    DP_S_ID,
    DP_S_JA,
    DP_S_JB,
    DP_S_JC,
    DP_S_JD,
    DP_S_JE,
    DP_F_UNDO,
    DP_F_CHK,
    DP_F_RH,
    DP_F_WL,
    DP_F_WH,
    DP_E_INIT,
    DP_E_RD,
    DP_E_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic k_last;
    logic cost_done;
    logic better;
    logic i_end;
    logic j_end;
    logic neg;
    logic flip_done;
    logic slot_ok;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/nearest_neighbor_two_opt_tour.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_two_opt_tour
// Distance matrix load, greedy nearest-neighbour tour, first-improvement
// 2-opt and city-by-city tour output with closed-loop cost.
// ----------------------------------------------------------------------------
// Distance write: one item per cycle while the block is idle, no result.
// Start item: greedy build with one distance memory read per candidate, then
//   first-improvement 2-opt: a pair test per candidate pair, a cost sum per
//   accepted move and a one-pair-per-pass reversal; overall data-dependent.
// Output: per result, a tour read then an emit held by out_stall (one read port).
// Reset: control cleared, city count set to MAX_CITIES; memories hold junk.
`default_nettype none

module nearest_neighbor_two_opt_tour #(
  parameter int unsigned MAX_CITIES = 64,
  parameter int unsigned DIST_BITS  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire nnt_pkg::in_item_t in_item_i,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output nnt_pkg::out_item_t     out_item_o,
  input  wire logic              cfg_we_i,
  input  wire logic [6:0]        cfg_data_i
);
  import nnt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  nnt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_op_i    (in_item_i.op[0]),
    .in_stall_o (in_stall),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  nnt_datapath #(
    .MAX_CITIES (MAX_CITIES),
    .DIST_BITS  (DIST_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- rtl/nnt_datapath.sv -----
// ----------------------------------------------------------------------------
// nnt_datapath
// Distance store, tour store, counters, accumulators and output register.
// Each cycle performs the step named by the controller's command.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_datapath #(
  parameter int unsigned MAX_CITIES = 64,
  parameter int unsigned DIST_BITS  = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire nnt_pkg::dp_cmd_t    cmd_i,
  output nnt_pkg::dp_status_t      status_o,
  input  wire nnt_pkg::in_item_t   in_item_i,
  input  wire logic                cfg_we_i,
  input  wire logic [6:0]          cfg_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output nnt_pkg::out_item_t       out_item_o
);
  import nnt_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_CITIES);
  localparam int unsigned K_W    = $clog2(MAX_CITIES + 2);
  localparam int unsigned DEPTH  = MAX_CITIES * MAX_CITIES;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CACC_W = (DIST_BITS + 7 > 23) ? DIST_BITS + 7 : 23;

  function automatic logic [AW-1:0] daddr(input logic [IDX_W-1:0] r,
                                          input logic [IDX_W-1:0] c);
    daddr = AW'(int'(r) * MAX_CITIES + int'(c));
  endfunction

  // storage
  logic [DIST_BITS-1:0] dist_mem [DEPTH];
  logic [IDX_W-1:0]     tour_mem [MAX_CITIES];

  logic                 dist_we;
  logic [AW-1:0]        dist_waddr, dist_raddr;
  logic [DIST_BITS-1:0] dist_wdata, dist_rd_q;
  logic                 tour_we;
  logic [IDX_W-1:0]     tour_waddr, tour_wdata, tour_raddr, tour_rd_q;

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_rd_q <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tour_we) begin
      tour_mem[tour_waddr] <= tour_wdata;
    end
    tour_rd_q <= tour_mem[tour_raddr];
  end

  // registers
  logic [K_W-1:0]        n_q, n_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [MAX_CITIES-1:0] visited_q, visited_d;
  logic                  found_q, found_d, pend_q, pend_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;
  logic [IDX_W-1:0]      cur_q, cur_d, pick_q, pick_d, jp_q, jp_d;
  logic [IDX_W-1:0]      first_q, first_d, prev_q, prev_d;
  logic [IDX_W-1:0]      a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, t_q, t_d;
  logic [IDX_W-1:0]      lo_q, lo_d, hi_q, hi_d, fl_q, fl_d, fh_q, fh_d;
  logic [DIST_BITS-1:0]  best_q, best_d, dab_q, dab_d;
  logic [DIST_BITS:0]    acc_q, acc_d;
  logic [CACC_W-1:0]     ncost_q, ncost_d, cost_q, cost_d;

  // helpers
  logic [K_W-1:0]   i1, jn, kn;
  logic             j_lt_n, k_lt_n, row_ok, col_ok, start_ok, eval_ok;
  logic [IDX_W-1:0] start_sel, nxt;
  logic [6:0]       cfg_clamped;
  logic [CACC_W-1:0] cost_sat;

  assign i1     = i_q + K_W'(1);
  assign jn     = j_q + K_W'(1);
  assign kn     = k_q + K_W'(1);
  assign j_lt_n = j_q < n_q;
  assign k_lt_n = k_q < n_q;
  assign row_ok = {1'b0, in_item_i.row_city} < 7'(MAX_CITIES);
  assign col_ok = {1'b0, in_item_i.col_city} < 7'(MAX_CITIES);
  assign start_ok  = {1'b0, in_item_i.start_city} < 7'(n_q);
  assign start_sel = start_ok ? in_item_i.start_city[IDX_W-1:0] : '0;
  assign eval_ok   = pend_q && !visited_q[jp_q] && (!found_q || dist_rd_q < best_q);
  assign nxt       = (k_q == n_q) ? first_q : tour_rd_q;
  assign cost_sat  = (cost_q > CACC_W'(COST_SAT)) ? CACC_W'(COST_SAT) : cost_q;

  always_comb begin
    if (cfg_data_i < 7'd2) begin
      cfg_clamped = 7'd2;
    end else if (cfg_data_i > 7'(MAX_CITIES)) begin
      cfg_clamped = 7'(MAX_CITIES);
    end else begin
      cfg_clamped = cfg_data_i;
    end
  end

  assign status_o.scan_done = (j_q == n_q) && !pend_q;
  assign status_o.k_last    = k_q == (n_q - K_W'(1));
  assign status_o.cost_done = k_q == (n_q + K_W'(1));
  assign status_o.better    = ncost_q < cost_q;
  assign status_o.i_end     = i1 >= n_q;
  assign status_o.j_end     = !j_lt_n;
  assign status_o.neg       = acc_q < ((DIST_BITS+1)'(dab_q) + (DIST_BITS+1)'(dist_rd_q));
  assign status_o.flip_done = fl_q >= fh_q;
  assign status_o.slot_ok   = !out_valid_q || !out_stall_i;

  always_comb begin
    n_d = cfg_we_i ? K_W'(cfg_clamped) : n_q;
    i_d = i_q; j_d = j_q; k_d = k_q;
    visited_d = visited_q; found_d = found_q; pend_d = pend_q;
    cur_d = cur_q; pick_d = pick_q; jp_d = jp_q; first_d = first_q; prev_d = prev_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; t_d = t_q;
    lo_d = lo_q; hi_d = hi_q; fl_d = fl_q; fh_d = fh_q;
    best_d = best_q; dab_d = dab_q; acc_d = acc_q; ncost_d = ncost_q; cost_d = cost_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    dist_we = 1'b0; dist_waddr = '0; dist_wdata = '0; dist_raddr = '0;
    tour_we = 1'b0; tour_waddr = '0; tour_wdata = '0; tour_raddr = '0;

    unique case (cmd_i.op)
      DP_NOP: ;
      DP_LOAD: begin
        dist_we    = row_ok && col_ok;
        dist_waddr = daddr(in_item_i.row_city[IDX_W-1:0], in_item_i.col_city[IDX_W-1:0]);
        dist_wdata = DIST_BITS'(in_item_i.distance);
      end
      DP_START: begin
        tour_we    = 1'b1;
        tour_waddr = '0;
        tour_wdata = start_sel;
        visited_d  = '0;
        visited_d[start_sel] = 1'b1;
        cur_d   = start_sel;
        k_d     = K_W'(1);
        j_d     = '0;
        found_d = 1'b0;
        pend_d  = 1'b0;
        cost_d  = '1;
      end
      DP_G_SCAN: begin
        dist_raddr = daddr(cur_q, j_q[IDX_W-1:0]);
        jp_d   = j_q[IDX_W-1:0];
        pend_d = j_lt_n;
        if (j_lt_n) begin
          j_d = jn;
        end
        // strictly closer only, so ties stay with the lower index
        if (eval_ok) begin
          found_d = 1'b1;
          best_d  = dist_rd_q;
          pick_d  = jp_q;
        end
      end
      DP_G_COMMIT: begin
        tour_we    = 1'b1;
        tour_waddr = k_q[IDX_W-1:0];
        tour_wdata = pick_q;
        visited_d[pick_q] = 1'b1;
        cur_d   = pick_q;
        k_d     = kn;
        j_d     = '0;
        found_d = 1'b0;
        pend_d  = 1'b0;
      end
      DP_C_INIT: begin
        tour_raddr = '0;
        k_d     = '0;
        ncost_d = '0;
      end
      DP_C_FIRST: begin
        first_d    = tour_rd_q;
        prev_d     = tour_rd_q;
        tour_raddr = IDX_W'(1);
        k_d        = K_W'(1);
      end
      DP_C_STEP: begin
        dist_raddr = daddr(prev_q, nxt);
        prev_d     = nxt;
        k_d        = kn;
      end
      DP_C_ACC: begin
        ncost_d    = ncost_q + CACC_W'(dist_rd_q);
        tour_raddr = k_lt_n ? k_q[IDX_W-1:0] : '0;
      end
      DP_C_END: begin
        if (ncost_q < cost_q) begin
          cost_d = ncost_q;
        end
      end
      DP_S_INIT: i_d = '0;
      DP_S_IA:   tour_raddr = i_q[IDX_W-1:0];
      DP_S_IB: begin
        a_d        = tour_rd_q;
        tour_raddr = i1[IDX_W-1:0];
      end
      DP_S_IC: begin
        b_d        = tour_rd_q;
        dist_raddr = daddr(a_q, tour_rd_q);
        j_d        = i_q + K_W'(2);
      end
      DP_S_ID: dab_d = dist_rd_q;
      DP_S_JA: begin
        tour_raddr = j_q[IDX_W-1:0];
        if (!j_lt_n) begin
          i_d = i1;
        end
      end
      DP_S_JB: begin
        c_d        = tour_rd_q;
        tour_raddr = (jn == n_q) ? '0 : jn[IDX_W-1:0];
        dist_raddr = daddr(a_q, tour_rd_q);
      end
      DP_S_JC: begin
        d_d        = tour_rd_q;
        acc_d      = (DIST_BITS+1)'(dist_rd_q);
        dist_raddr = daddr(b_q, tour_rd_q);
      end
      DP_S_JD: begin
        acc_d      = acc_q + (DIST_BITS+1)'(dist_rd_q);
        dist_raddr = daddr(c_q, d_q);
      end
      DP_S_JE: begin
        lo_d = i1[IDX_W-1:0];
        hi_d = j_q[IDX_W-1:0];
        fl_d = i1[IDX_W-1:0];
        fh_d = j_q[IDX_W-1:0];
        j_d  = jn;
      end
      DP_F_UNDO: begin
        fl_d = lo_q;
        fh_d = hi_q;
      end
      DP_F_CHK: tour_raddr = fl_q;
      DP_F_RH: begin
        t_d        = tour_rd_q;
        tour_raddr = fh_q;
      end
      DP_F_WL: begin
        tour_we    = 1'b1;
        tour_waddr = fl_q;
        tour_wdata = tour_rd_q;
      end
      DP_F_WH: begin
        tour_we    = 1'b1;
        tour_waddr = fh_q;
        tour_wdata = t_q;
        fl_d       = fl_q + IDX_W'(1);
        fh_d       = fh_q - IDX_W'(1);
      end
      DP_E_INIT: k_d = '0;
      DP_E_RD:   tour_raddr = k_q[IDX_W-1:0];
      DP_E_OUT: begin
        tour_raddr = k_q[IDX_W-1:0];
        if (status_o.slot_ok) begin
          out_valid_d          = 1'b1;
          out_item_d.position  = 6'(k_q[IDX_W-1:0]);
          out_item_d.city      = 6'(tour_rd_q);
          out_item_d.tour_cost = COST_W'(cost_sat);
          out_item_d.last      = status_o.k_last;
          k_d                  = kn;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= K_W'(MAX_CITIES);
      visited_q   <= '0;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      fl_q        <= '0;
      fh_q        <= '0;
    end else begin
      n_q         <= n_d;
      visited_q   <= visited_d;
      found_q     <= found_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      fl_q        <= fl_d;
      fh_q        <= fh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; pick_q <= pick_d; jp_q <= jp_d; first_q <= first_d; prev_q <= prev_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; t_q <= t_d;
    lo_q <= lo_d; hi_q <= hi_d;
    best_q <= best_d; dab_q <= dab_d; acc_q <= acc_d;
    ncost_q <= ncost_d; cost_q <= cost_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_E_OUT && status_o.slot_ok) |=> out_valid_q)
    else $error("result slot not loaded");

  a_pick_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_G_COMMIT) |-> (found_q && !visited_q[pick_q]))
    else $error("greedy step picked a visited city");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_S_JE) |-> (j_q < n_q && (i_q + K_W'(2)) <= j_q))
    else $error("2-opt pair out of range");

endmodule

`default_nettype wire

// ----- rtl/nnt_ctrl.sv -----
// ----------------------------------------------------------------------------
// nnt_ctrl
// Sequencer for load, greedy build, cost sum, 2-opt scan, segment reversal
// and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_op_i,
  output logic                     in_stall_o,
  output nnt_pkg::dp_cmd_t         cmd_o,
  input  wire nnt_pkg::dp_status_t status_i
);
  import nnt_pkg::*;

  typedef enum logic [25:0] {
    ST_IDLE     = 26'd1 << 0,
    ST_G_SCAN   = 26'd1 << 1,
    ST_G_COMMIT = 26'd1 << 2,
    ST_C_INIT   = 26'd1 << 3,
    ST_C_FIRST  = 26'd1 << 4,
    ST_C_STEP   = 26'd1 << 5,
    ST_C_ACC    = 26'd1 << 6,
    ST_C_END    = 26'd1 << 7,
    ST_S_INIT   = 26'd1 << 8,
    ST_S_IA     = 26'd1 << 9,
    ST_S_IB     = 26'd1 << 10,
    ST_S_IC     = 26'd1 << 11,
    ST_S_ID     = 26'd1 << 12,
    ST_S_JA     = 26'd1 << 13,
    ST_S_JB     = 26'd1 << 14,
    ST_S_JC     = 26'd1 << 15,
    ST_S_JD     = 26'd1 << 16,
    ST_S_JE     = 26'd1 << 17,
    ST_F_UNDO   = 26'd1 << 18,
    ST_F_CHK    = 26'd1 << 19,
    ST_F_RH     = 26'd1 << 20,
    ST_F_WL     = 26'd1 << 21,
    ST_F_WH     = 26'd1 << 22,
    ST_E_INIT   = 26'd1 << 23,
    ST_E_RD     = 26'd1 << 24,
    ST_E_OUT    = 26'd1 << 25
  } state_e;

  state_e state_q, state_d;
  logic   undo_q, undo_d;

  assign in_stall_o = state_q != ST_IDLE;

  always_comb begin
    state_d   = state_q;
    undo_d    = undo_q;
    cmd_o.op  = DP_NOP;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_START) begin
            cmd_o.op = DP_START;
            state_d  = ST_G_SCAN;
          end else begin
            cmd_o.op = DP_LOAD;
          end
        end
      end
      ST_G_SCAN: begin
        cmd_o.op = DP_G_SCAN;
        if (status_i.scan_done) state_d = ST_G_COMMIT;
      end
      ST_G_COMMIT: begin
        cmd_o.op = DP_G_COMMIT;
        state_d  = status_i.k_last ? ST_C_INIT : ST_G_SCAN;
      end
      ST_C_INIT: begin
        cmd_o.op = DP_C_INIT;
        state_d  = ST_C_FIRST;
      end
      ST_C_FIRST: begin
        cmd_o.op = DP_C_FIRST;
        state_d  = ST_C_STEP;
      end
      ST_C_STEP: begin
        cmd_o.op = DP_C_STEP;
        state_d  = ST_C_ACC;
      end
      ST_C_ACC: begin
        cmd_o.op = DP_C_ACC;
        state_d  = status_i.cost_done ? ST_C_END : ST_C_STEP;
      end
      ST_C_END: begin
        // a reversal that does not lower the true cost is taken back
        cmd_o.op = DP_C_END;
        state_d  = status_i.better ? ST_S_INIT : ST_F_UNDO;
      end
      ST_S_INIT: begin
        cmd_o.op = DP_S_INIT;
        state_d  = ST_S_IA;
      end
      ST_S_IA: begin
        cmd_o.op = DP_S_IA;
        state_d  = status_i.i_end ? ST_E_INIT : ST_S_IB;
      end
      ST_S_IB: begin
        cmd_o.op = DP_S_IB;
        state_d  = ST_S_IC;
      end
      ST_S_IC: begin
        cmd_o.op = DP_S_IC;
        state_d  = ST_S_ID;
      end
      ST_S_ID: begin
        cmd_o.op = DP_S_ID;
        state_d  = ST_S_JA;
      end
      ST_S_JA: begin
        cmd_o.op = DP_S_JA;
        state_d  = status_i.j_end ? ST_S_IA : ST_S_JB;
      end
      ST_S_JB: begin
        cmd_o.op = DP_S_JB;
        state_d  = ST_S_JC;
      end
      ST_S_JC: begin
        cmd_o.op = DP_S_JC;
        state_d  = ST_S_JD;
      end
      ST_S_JD: begin
        cmd_o.op = DP_S_JD;
        state_d  = ST_S_JE;
      end
      ST_S_JE: begin
        cmd_o.op = DP_S_JE;
        if (status_i.neg) begin
          undo_d  = 1'b0;
          state_d = ST_F_CHK;
        end else begin
          state_d = ST_S_JA;
        end
      end
      ST_F_UNDO: begin
        cmd_o.op = DP_F_UNDO;
        undo_d   = 1'b1;
        state_d  = ST_F_CHK;
      end
      ST_F_CHK: begin
        cmd_o.op = DP_F_CHK;
        if (status_i.flip_done) begin
          state_d = undo_q ? ST_E_INIT : ST_C_INIT;
        end else begin
          state_d = ST_F_RH;
        end
      end
      ST_F_RH: begin
        cmd_o.op = DP_F_RH;
        state_d  = ST_F_WL;
      end
      ST_F_WL: begin
        cmd_o.op = DP_F_WL;
        state_d  = ST_F_WH;
      end
      ST_F_WH: begin
        cmd_o.op = DP_F_WH;
        state_d  = ST_F_CHK;
      end
      ST_E_INIT: begin
        cmd_o.op = DP_E_INIT;
        state_d  = ST_E_RD;
      end
      ST_E_RD: begin
        cmd_o.op = DP_E_RD;
        state_d  = ST_E_OUT;
      end
      ST_E_OUT: begin
        cmd_o.op = DP_E_OUT;
        if (status_i.slot_ok) begin
          state_d = status_i.k_last ? ST_IDLE : ST_E_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      undo_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      undo_q  <= undo_d;
    end
  end

endmodule

`default_nettype wire

// ----- tb/nearest_neighbor_two_opt_tour_tb.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_two_opt_tour_tb
// Loads distance matrices, starts tours and checks every emitted tour item
// against a behavioural nearest-neighbour plus 2-opt tour predictor, under
// several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_neighbor_two_opt_tour_tb;
  import nnt_pkg::*;

  localparam int unsigned NCITY      = 64;
  localparam int unsigned IDLE_LIMIT = 400000;
  localparam int          N_ITEMS    = 420;
  localparam int          HOLD_CYCLES = 3000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum int {MAT_LINE, MAT_SYM, MAT_ASYM, MAT_CONST} matrix_kind_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item_i = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_we_i = 1'b0;
  logic [6:0] cfg_data_i = '0;

  idle_mode_e idle_mode = IDLE_NONE;
  int         hold_req_cnt = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         mismatches = 0;
  int         quiet_cycles = 0;
  int         sent_items = 0;

  // predictor state
  logic [15:0] dist_mem [NCITY][NCITY];
  int          tour_cnt = NCITY;
  int          tour_sim [NCITY];
  out_item_t   tour_q [$];

  always #5 clk_i = ~clk_i;

  nearest_neighbor_two_opt_tour DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item_i  (in_item_i),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  function automatic longint loop_len(int n);
    longint s;
    s = 0;
    for (int k = 0; k < n; k++)
      s += longint'(dist_mem[tour_sim[k]][tour_sim[(k + 1) % n]]);
    return s;
  endfunction

  function automatic void reverse_span(int lo, int hi);
    int t;
    while (lo < hi) begin
      t = tour_sim[lo];
      tour_sim[lo] = tour_sim[hi];
      tour_sim[hi] = t;
      lo++;
      hi--;
    end
  endfunction

  // greedy build, then first-improvement 2-opt; queue one item per position
  function automatic void predict_tour(logic [5:0] start);
    int        n, cur, pick, lo, hi;
    bit        seen [NCITY];
    bit        found, moved;
    longint    pd, cost, nc, delta;
    out_item_t r;
    n = tour_cnt;
    cur = (int'(start) >= n) ? 0 : int'(start);
    foreach (seen[k]) seen[k] = 1'b0;
    tour_sim[0] = cur;
    seen[cur] = 1'b1;
    for (int k = 1; k < n; k++) begin
      found = 1'b0;
      pick = 0;
      pd = 0;
      for (int j = 0; j < n; j++) begin
        if (!seen[j] && (!found || longint'(dist_mem[cur][j]) < pd)) begin
          found = 1'b1;
          pd = longint'(dist_mem[cur][j]);
          pick = j;
        end
      end
      tour_sim[k] = pick;
      seen[pick] = 1'b1;
      cur = pick;
    end
    cost = loop_len(n);
    forever begin
      moved = 1'b0;
      for (int i = 0; i + 1 < n && !moved; i++) begin
        for (int j = i + 2; j < n && !moved; j++) begin
          delta = longint'(dist_mem[tour_sim[i]][tour_sim[j]])
                + longint'(dist_mem[tour_sim[i + 1]][tour_sim[(j + 1) % n]])
                - longint'(dist_mem[tour_sim[i]][tour_sim[i + 1]])
                - longint'(dist_mem[tour_sim[j]][tour_sim[(j + 1) % n]]);
          if (delta < 0) begin
            reverse_span(i + 1, j);
            lo = i + 1;
            hi = j;
            moved = 1'b1;
          end
        end
      end
      if (!moved) break;
      nc = loop_len(n);
      // asymmetric matrix: a reversal that does not help is undone and the search ends
      if (nc >= cost) begin
        reverse_span(lo, hi);
        break;
      end
      cost = nc;
    end
    if (cost > longint'(COST_SAT)) cost = longint'(COST_SAT);
    for (int k = 0; k < n; k++) begin
      r.position  = k[5:0];
      r.city      = tour_sim[k][5:0];
      r.tour_cost = cost[COST_W-1:0];
      r.last      = (k == n - 1);
      tour_q = {tour_q, r};
    end
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_item(in_item_t it);
    if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
      while ($urandom_range(99) < ((idle_mode == IDLE_SEND) ? 79 : 8)) begin
        in_valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid  <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall);
    sent_items++;
    if (it.op == OP_START) predict_tour(it.start_city);
    else dist_mem[it.row_city][it.col_city] = it.distance;
    @(negedge clk_i);
  endtask

  task automatic write_dist(int r, int c, logic [15:0] d);
    in_item_t it;
    it.op         = OP_WRITE_DIST;
    it.row_city   = r[5:0];
    it.col_city   = c[5:0];
    it.distance   = d;
    it.start_city = 6'($urandom_range(63));
    send_item(it);
  endtask

  task automatic start_tour(logic [5:0] s);
    in_item_t it;
    it.op         = OP_START;
    it.row_city   = 6'($urandom_range(63));
    it.col_city   = 6'($urandom_range(63));
    it.distance   = 16'($urandom);
    it.start_city = s;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tour_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_city_count(logic [6:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tour_cnt = (v < 7'd2) ? 2 : (int'(v) > int'(NCITY)) ? int'(NCITY) : int'(v);
  endtask

  function automatic logic [15:0] rand_dist();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(3));
      1:       return 16'($urandom_range(40));
      2:       return 16'($urandom);
      default: return 16'hFFFF - 16'($urandom_range(3));
    endcase
  endfunction

  // every entry of the n x n block, diagonal included
  task automatic load_matrix(int n, matrix_kind_e kind, logic [15:0] fill = '0);
    logic [15:0] m [NCITY][NCITY];
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        case (kind)
          MAT_LINE:  m[r][c] = 16'((r > c) ? r - c : c - r);
          MAT_CONST: m[r][c] = fill;
          MAT_ASYM:  m[r][c] = rand_dist();
          default:   m[r][c] = (c < r) ? m[c][r] : rand_dist();
        endcase
      end
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) write_dist(r, c, m[r][c]);
  endtask

  // ------------------------------------------------------------------ tests

  task automatic test_line_matrix();
    set_city_count(7'd10);
    idle_mode = IDLE_NONE;
    load_matrix(10, MAT_LINE);
    start_tour(6'd0);
    start_tour(6'd9);
  endtask

  task automatic test_two_cities();
    set_city_count(7'd1);
    idle_mode = IDLE_NONE;
    load_matrix(2, MAT_SYM);
    start_tour(6'd0);
    start_tour(6'd1);
    start_tour(6'd63);
    set_city_count(7'd0);
    start_tour(6'd2);
  endtask

  task automatic test_max_distance();
    set_city_count(7'd3);
    idle_mode = IDLE_SEND;
    load_matrix(3, MAT_CONST, 16'hFFFF);
    start_tour(6'd2);
  endtask

  task automatic test_ties();
    set_city_count(7'd5);
    idle_mode = IDLE_RECV;
    load_matrix(5, MAT_CONST, 16'd7);
    start_tour(6'd3);
    load_matrix(5, MAT_CONST, 16'd0);
    start_tour(6'd4);
  endtask

  task automatic test_asymmetric();
    set_city_count(7'd6);
    idle_mode = IDLE_BOTH;
    load_matrix(6, MAT_ASYM);
    for (int k = 0; k < 3; k++) start_tour(6'($urandom_range(63)));
  endtask

  task automatic test_backpressure();
    set_city_count(7'd7);
    idle_mode = IDLE_NONE;
    load_matrix(7, MAT_SYM);
    hold_req_cnt++;
    for (int k = 0; k < 5; k++) start_tour(6'($urandom_range(6)));
    drain();
  endtask

  task automatic test_random();
    int n;
    while (sent_items < N_ITEMS) begin
      n = $urandom_range(2, 8);
      set_city_count(7'(n));
      idle_mode = idle_mode_e'($urandom_range(3));
      load_matrix(n, ($urandom_range(3) == 0) ? MAT_ASYM : MAT_SYM);
      repeat ($urandom_range(1, 4)) begin
        // stray writes outside the active block add noise
        if ($urandom_range(2) == 0)
          write_dist(int'($urandom_range(63, n)), int'($urandom_range(63)),
                     16'($urandom));
        start_tour(6'($urandom_range(63)));
      end
    end
  endtask

  // --------------------------------------------------------------- checking

  // a new hold request from a test starts a long receiver stall
  always @(negedge clk_i) begin
    if (hold_req_cnt != hold_seen) begin
      hold_seen <= hold_req_cnt;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      case (idle_mode)
        IDLE_RECV: out_stall <= ($urandom_range(99) < 79);
        IDLE_BOTH: out_stall <= ($urandom_range(99) < 8);
        default:   out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (tour_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tour item %p", out_item_o);
      end else begin
        e = tour_q.pop_front();
        if (out_item_o.position !== e.position || out_item_o.city !== e.city ||
            out_item_o.tour_cost !== e.tour_cost || out_item_o.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"tour item mismatch: exp pos %0d city %0d cost %0d last %0d,",
                      " got %0d %0d %0d %0d"},
                     e.position, e.city, e.tour_cost, e.last, out_item_o.position,
                     out_item_o.city, out_item_o.tour_cost, out_item_o.last);
        end
      end
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_line_matrix();
    test_two_cities();
    test_max_distance();
    test_ties();
    test_asymmetric();
    test_backpressure();
    test_random();
    drain();
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && tour_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
